// ----- src/tx_ring_with_atomic_reply_staging_macros.svh -----
// Assertion macros shared by the transmit ring RTL.
// Expects a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef TX_RING_WITH_ATOMIC_REPLY_STAGING_MACROS_SVH
`define TX_RING_WITH_ATOMIC_REPLY_STAGING_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TXR_ASSERT_HOLDS(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("txr: same-cycle check failed");
`define TXR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("txr: next-cycle check failed");
`else
`define TXR_ASSERT_HOLDS(label, ante, cons)
`define TXR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/txr_pkg.sv -----
// Shared constants, types and index helpers of the transmit ring block.
// No dependencies; used by txr_ctrl and the top level.
package txr_pkg;

    localparam int RING_SLOTS = 32;
    localparam int STAGE_CAP  = RING_SLOTS - 1;
    localparam int IDX_W      = $clog2(RING_SLOTS);
    localparam int STG_AW     = (STAGE_CAP > 1) ? $clog2(STAGE_CAP) : 1;
    localparam int CMP_W      = ((IDX_W > 8) ? IDX_W : 8) + 1;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       reply_first;
        logic [7:0] reply_length;
        logic       terminal_ready;
        logic       uart_writable;
    } t_item;

    typedef struct packed {
        logic       uart_valid;
        logic [7:0] uart_byte;
        logic [4:0] ring_free;
        logic       ring_empty;
        logic [4:0] staged_count;
        logic       reply_refused;
        logic       overflow;
    } t_result;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ring_req;

    typedef struct packed {
        logic              we;
        logic [STG_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [STG_AW-1:0] raddr;
    } t_stg_req;

    function automatic logic [IDX_W-1:0] nxt_idx(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(RING_SLOTS - 1)) ? '0 : x + 1'b1;
    endfunction

    // Free slots: (ri - wi - 1) modulo RING_SLOTS
    function automatic logic [IDX_W-1:0] free_slots(input logic [IDX_W-1:0] ri,
                                                    input logic [IDX_W-1:0] wi);
        logic [IDX_W:0] t;
        t = {1'b0, ri} + (IDX_W+1)'(RING_SLOTS - 1) - {1'b0, wi};
        if (t >= (IDX_W+1)'(RING_SLOTS)) begin
            t = t - (IDX_W+1)'(RING_SLOTS);
        end
        return t[IDX_W-1:0];
    endfunction

endpackage

// ----- src/txr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module txr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/txr_ctrl.sv -----
// Sequencer of the transmit ring: push, reply staging, promotion and drain.
// Depends on txr_pkg and the assertion macro header; drives both RAMs.
`include "tx_ring_with_atomic_reply_staging_macros.svh"
module txr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  txr_pkg::t_item     i_item,
    input  logic               i_suppress,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output txr_pkg::t_result   o_res,
    output txr_pkg::t_ring_req o_ring_req,
    input  logic [7:0]         i_ring_rdata,
    output txr_pkg::t_stg_req  o_stg_req,
    input  logic [7:0]         i_stg_rdata
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_COPY   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                r_state,   n_state;
    txr_pkg::t_item            r_item,    n_item;
    logic [txr_pkg::IDX_W-1:0] r_wi,      n_wi;
    logic [txr_pkg::IDX_W-1:0] r_ri,      n_ri;
    logic [txr_pkg::IDX_W-1:0] r_stg_cnt, n_stg_cnt;
    logic [txr_pkg::IDX_W-1:0] r_cp_idx,  n_cp_idx;
    logic                      r_taking,  n_taking;
    logic [7:0]                r_left,    n_left;
    logic                      r_refused, n_refused;
    logic                      r_ovf,     n_ovf;
    logic                      r_uvalid,  n_uvalid;
    logic [7:0]                r_ubyte,   n_ubyte;

    txr_pkg::t_ring_req        ring_req;
    txr_pkg::t_stg_req         stg_req;

    logic                      v_taking;
    logic [7:0]                v_left;
    logic                      v_refused;
    logic [txr_pkg::IDX_W-1:0] v_cp_next;
    logic [txr_pkg::IDX_W-1:0] v_free;

    assign v_free    = txr_pkg::free_slots(r_ri, r_wi);
    assign v_cp_next = r_cp_idx + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_wi      = r_wi;
        n_ri      = r_ri;
        n_stg_cnt = r_stg_cnt;
        n_cp_idx  = r_cp_idx;
        n_taking  = r_taking;
        n_left    = r_left;
        n_refused = r_refused;
        n_ovf     = r_ovf;
        n_uvalid  = r_uvalid;
        n_ubyte   = r_ubyte;
        ring_req  = '0;
        stg_req   = '0;
        v_taking  = r_taking;
        v_left    = r_left;
        v_refused = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item    = i_item;
                    n_refused = 1'b0;
                    n_ovf     = 1'b0;
                    n_uvalid  = 1'b0;
                    n_ubyte   = 8'd0;
                    n_state   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_item.cmd)
                    txr_pkg::CMD_PUSH: begin
                        if (v_free == '0) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_wi           = txr_pkg::nxt_idx(r_wi);
                            ring_req.we    = 1'b1;
                            ring_req.waddr = n_wi;
                            ring_req.wdata = r_item.data_byte;
                        end
                    end
                    txr_pkg::CMD_REPLY: begin
                        if (r_item.reply_first) begin
                            v_taking = 1'b0;
                            v_left   = 8'd0;
                            if (i_suppress || r_item.terminal_ready ||
                                (txr_pkg::CMP_W'(r_item.reply_length) >
                                 txr_pkg::CMP_W'(txr_pkg::STAGE_CAP) -
                                 txr_pkg::CMP_W'(r_stg_cnt))) begin
                                v_refused = 1'b1;
                            end else begin
                                v_taking = (r_item.reply_length != 8'd0);
                                v_left   = r_item.reply_length;
                            end
                        end
                        if (!v_refused) begin
                            if (v_taking && (v_left != 8'd0) &&
                                (r_stg_cnt < txr_pkg::IDX_W'(txr_pkg::STAGE_CAP))) begin
                                stg_req.we    = 1'b1;
                                stg_req.waddr = r_stg_cnt[txr_pkg::STG_AW-1:0];
                                stg_req.wdata = r_item.data_byte;
                                n_stg_cnt     = r_stg_cnt + 1'b1;
                                v_left        = v_left - 8'd1;
                                if (v_left == 8'd0) begin
                                    v_taking = 1'b0;
                                end
                            end else begin
                                v_refused = 1'b1;
                            end
                        end
                        n_taking  = v_taking;
                        n_left    = v_left;
                        n_refused = v_refused;
                    end
                    txr_pkg::CMD_TICK: begin
                        // promote only a complete reply into an empty ring
                        if ((r_stg_cnt != '0) && (r_wi == r_ri) && !r_taking) begin
                            stg_req.re    = 1'b1;
                            stg_req.raddr = '0;
                            n_cp_idx      = '0;
                            n_state       = ST_COPY;
                        end else begin
                            n_state = ST_DRAIN;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_COPY: begin
                n_wi           = txr_pkg::nxt_idx(r_wi);
                ring_req.we    = 1'b1;
                ring_req.waddr = n_wi;
                ring_req.wdata = i_stg_rdata;
                if (r_cp_idx == r_stg_cnt - 1'b1) begin
                    n_stg_cnt = '0;
                    n_state   = ST_DRAIN;
                end else begin
                    stg_req.re    = 1'b1;
                    stg_req.raddr = v_cp_next[txr_pkg::STG_AW-1:0];
                    n_cp_idx      = v_cp_next;
                end
            end
            ST_DRAIN: begin
                if ((r_wi != r_ri) && r_item.uart_writable) begin
                    n_ri           = txr_pkg::nxt_idx(r_ri);
                    ring_req.re    = 1'b1;
                    ring_req.raddr = n_ri;
                    n_state        = ST_RDWAIT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RDWAIT: begin
                n_uvalid = 1'b1;
                n_ubyte  = i_ring_rdata;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wi      <= '0;
            r_ri      <= '0;
            r_stg_cnt <= '0;
            r_taking  <= 1'b0;
            r_left    <= 8'd0;
        end else begin
            r_state   <= n_state;
            r_wi      <= n_wi;
            r_ri      <= n_ri;
            r_stg_cnt <= n_stg_cnt;
            r_taking  <= n_taking;
            r_left    <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_cp_idx  <= n_cp_idx;
        r_refused <= n_refused;
        r_ovf     <= n_ovf;
        r_uvalid  <= n_uvalid;
        r_ubyte   <= n_ubyte;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_ring_req  = ring_req;
    assign o_stg_req   = stg_req;

    assign o_res.uart_valid    = r_uvalid;
    assign o_res.uart_byte     = r_ubyte;
    assign o_res.ring_free     = 5'(v_free);
    assign o_res.ring_empty    = (r_wi == r_ri);
    assign o_res.staged_count  = 5'(r_stg_cnt);
    assign o_res.reply_refused = r_refused;
    assign o_res.overflow      = r_ovf;

    `TXR_ASSERT_HOLDS(a_stg_bound, 1'b1, r_stg_cnt <= txr_pkg::IDX_W'(txr_pkg::STAGE_CAP))
    `TXR_ASSERT_HOLDS(a_taking_left, 1'b1, r_taking == (r_left != 8'd0))
    `TXR_ASSERT_HOLDS(a_ring_port, ring_req.we, !ring_req.re)
    `TXR_ASSERT_HOLDS(a_copy_room, r_state == ST_COPY, txr_pkg::nxt_idx(r_wi) != r_ri)
    `TXR_ASSERT_NEXT(a_read_wait, r_state == ST_DRAIN && ring_req.re, r_state == ST_RDWAIT)
endmodule

// ----- src/tx_ring_with_atomic_reply_staging.sv -----
// Top level of the transmit byte ring with atomic reply staging.
// Depends on txr_pkg, txr_ram (ring and staging stores) and txr_ctrl.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata, tuser = cmd
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata = result item
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_data = reply_suppress
//
// States: a push, a reply byte or an unused command goes through EXEC to DONE;
// a tick goes through EXEC, COPY when it promotes the staging buffer (one
// staging RAM read and one ring RAM write per cycle), DRAIN, and RDWAIT when
// it sends a byte. From DONE the result enters the output register. The next
// transaction is taken in the cycle after the result leaves the sequencer.
// Reset clears the indexes, counts and reply tracking; the RAM contents are not
// cleared, as only written entries are ever read. No clearing pass.
// A stalled m_axis holds the result in the output register; the next item is
// still taken and processed, and waits in the sequencer until the register frees.
module tx_ring_with_atomic_reply_staging (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] data_byte, [8] reply_first, [16:9] reply_length,
    // [17] terminal_ready, [18] uart_writable, [23:19] zero
    input  logic [txr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [1:0] cmd
    input  logic [txr_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] uart_valid, [8:1] uart_byte, [13:9] ring_free, [14] ring_empty,
    // [19:15] staged_count, [20] reply_refused, [21] overflow, [23:22] zero
    output logic [txr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);
    txr_pkg::t_item     item;
    txr_pkg::t_result   res;
    txr_pkg::t_ring_req ring_req;
    txr_pkg::t_stg_req  stg_req;
    logic [7:0]         ring_rdata;
    logic [7:0]         stg_rdata;
    logic               res_valid;
    logic               res_ready;

    logic                               r_suppress;
    logic                               r_out_valid;
    logic [txr_pkg::OUT_TDATA_W-1:0]    r_out_data;

    // unpack the input transaction
    assign item.cmd            = s_axis_tuser[1:0];
    assign item.data_byte      = s_axis_tdata[7:0];
    assign item.reply_first    = s_axis_tdata[8];
    assign item.reply_length   = s_axis_tdata[16:9];
    assign item.terminal_ready = s_axis_tdata[17];
    assign item.uart_writable  = s_axis_tdata[18];

    // configuration register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppress <= 1'b0;
        end else if (i_cfg_valid) begin
            r_suppress <= i_cfg_data;
        end
    end

    txr_ram #(
        .DEPTH (txr_pkg::RING_SLOTS),
        .WIDTH (8)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_req.we),
        .i_waddr (ring_req.waddr),
        .i_wdata (ring_req.wdata),
        .i_re    (ring_req.re),
        .i_raddr (ring_req.raddr),
        .o_rdata (ring_rdata)
    );

    txr_ram #(
        .DEPTH (txr_pkg::STAGE_CAP),
        .WIDTH (8)
    ) u_stg_ram (
        .i_clk   (i_clk),
        .i_we    (stg_req.we),
        .i_waddr (stg_req.waddr),
        .i_wdata (stg_req.wdata),
        .i_re    (stg_req.re),
        .i_raddr (stg_req.raddr),
        .o_rdata (stg_rdata)
    );

    txr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_item       (item),
        .i_suppress   (r_suppress),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_ring_req   (ring_req),
        .i_ring_rdata (ring_rdata),
        .o_stg_req    (stg_req),
        .i_stg_rdata  (stg_rdata)
    );

    // output register: load when empty or being drained this cycle
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= {2'b00, res.overflow, res.reply_refused, res.staged_count,
                           res.ring_empty, res.ring_free, res.uart_byte, res.uart_valid};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
endmodule
